// ===== rtl/pfs_pkg.sv =====
// Package for the protobuf field scanner: beat types, phase codes,
// status codes and default sizes. No dependencies.
`timescale 1ns / 1ps

package pfs_pkg;

  // Default width of the running byte offset inside a message.
  localparam int OFFSET_BITS_DEFAULT = 16;

  // Width of the offsets reported in a result.
  localparam int OFS_OUT_BITS = 16;

  // Scan phases.
  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_VARINT = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TRUNCATED   = 2'd1;
  localparam logic [1:0] ST_VARINT_LONG = 2'd2;
  localparam logic [1:0] ST_MSG_LONG    = 2'd3;

  // Wire types that carry a value.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Index of the last varint group; a continuation bit there is an error.
  localparam logic [3:0] LAST_GROUP = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } scan_in_t;

  typedef struct packed {
    logic [31:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [15:0] value_start;
    logic [15:0] value_end;
    logic [1:0]  status;
    logic        message_done;
  } scan_out_t;

endpackage

// ===== rtl/protobuf_field_scanner_top.sv =====
// Top level of the protobuf field scanner: byte-serial wire-format scan,
// result register and skid stage. Depends on pfs_pkg.
`timescale 1ns / 1ps

// The scanner takes a protocol buffers message one byte per beat, with
// last_byte set on the final byte, and emits one result beat for each field
// that completes: its field number, wire type, varint value (type 0) or
// length (type 2), and the offsets where its value starts and ends. An error
// (truncated field, varint longer than ten bytes, or a message that runs
// past 2^OFFSET_BITS - 1 bytes) silences the scanner until the message's last
// byte, which then carries one result with the error status and all other
// fields zero. A byte is taken in every cycle that the input is not stalled:
// all the per-byte work (the varint group merge, the tag split and the 64-bit
// skip countdown) happens in the cycle the byte is accepted; its result is
// registered in the result register, backed by a one-beat skid stage, so
// the input is stalled only while both hold a result that the downstream
// side has not yet taken. There is no clearing pass after reset.
module protobuf_field_scanner_top
  import pfs_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  scan_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output scan_out_t result
);

  // Scan state.
  logic [1:0]             phase,         phase_next;
  logic [63:0]            accumulator,   accumulator_next;
  logic [3:0]             group_count,   group_count_next;
  logic [31:0]            held_field,    held_field_next;
  logic [2:0]             held_type,     held_type_next;
  logic [OFFSET_BITS-1:0] start_offset,  start_offset_next;
  logic [63:0]            bytes_to_skip, bytes_to_skip_next;
  logic [OFFSET_BITS-1:0] byte_offset,   byte_offset_next;
  logic [1:0]             error_seen,    error_seen_next;

  // Output register and skid stage.
  logic      skid_valid;
  scan_out_t skid;

  logic                              accept;
  logic                              out_free;
  logic                              emit;
  logic                              produce;
  scan_out_t                         res_new;
  logic [6:0]                        shamt;
  logic [63:0]                       merged;
  logic [1:0]                        final_status;
  logic [OFFSET_BITS+OFS_OUT_BITS-1:0] start_wide;
  logic [OFFSET_BITS+OFS_OUT_BITS-1:0] end_wide;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign out_free   = !result_valid || !result_stall;

  // Seven bits per group: shift = 8 * count - count.
  assign shamt  = {group_count, 3'b000} - {3'b000, group_count};
  assign merged = accumulator | ({57'b0, item.data_byte[6:0]} << shamt);

  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    group_count_next   = group_count;
    held_field_next    = held_field;
    held_type_next     = held_type;
    start_offset_next  = start_offset;
    bytes_to_skip_next = bytes_to_skip;
    byte_offset_next   = byte_offset;
    error_seen_next    = error_seen;
    emit               = 1'b0;
    produce            = 1'b0;
    res_new            = '0;
    final_status       = ST_OK;
    start_wide         = '0;
    end_wide           = '0;

    if (accept) begin
      if (error_seen == ST_OK) begin
        if (&byte_offset) begin
          error_seen_next = ST_MSG_LONG;
        end else begin
          byte_offset_next = byte_offset + 1'b1;
          unique case (phase) inside
            PH_TAG, PH_VARINT: begin
              if (item.data_byte[7]) begin
                accumulator_next = merged;
                if (group_count >= LAST_GROUP) begin
                  error_seen_next = ST_VARINT_LONG;
                end else begin
                  group_count_next = group_count + 1'b1;
                end
              end else begin
                accumulator_next = '0;
                group_count_next = '0;
                if (phase == PH_TAG) begin
                  held_field_next   = merged[34:3];
                  held_type_next    = merged[2:0];
                  start_offset_next = byte_offset_next;
                  if (merged[2:0] == WT_VARINT || merged[2:0] == WT_LEN) begin
                    phase_next = PH_VARINT;
                  end else if (merged[2:0] == WT_FIXED64) begin
                    phase_next         = PH_SKIP;
                    bytes_to_skip_next = 64'd8;
                  end else if (merged[2:0] == WT_FIXED32) begin
                    phase_next         = PH_SKIP;
                    bytes_to_skip_next = 64'd4;
                  end else begin
                    emit = 1'b1;
                  end
                end else if (held_type == WT_LEN && merged != 64'd0) begin
                  phase_next         = PH_SKIP;
                  bytes_to_skip_next = merged;
                  accumulator_next   = merged;
                end else begin
                  emit                = 1'b1;
                  res_new.field_value = merged;
                end
              end
            end
            PH_SKIP: begin
              if (bytes_to_skip != 64'd0) begin
                bytes_to_skip_next = bytes_to_skip - 64'd1;
              end
              if (bytes_to_skip_next == 64'd0) begin
                emit                = 1'b1;
                res_new.field_value = (held_type == WT_LEN) ? accumulator : 64'd0;
                accumulator_next    = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      if (emit) begin
        phase_next           = PH_TAG;
        produce              = 1'b1;
        start_wide           = {{OFS_OUT_BITS{1'b0}}, start_offset_next};
        end_wide             = {{OFS_OUT_BITS{1'b0}}, byte_offset_next};
        res_new.field_id     = held_field_next;
        res_new.wire_kind    = held_type_next;
        res_new.value_start  = start_wide[OFS_OUT_BITS-1:0];
        res_new.value_end    = end_wide[OFS_OUT_BITS-1:0];
        res_new.status       = ST_OK;
        res_new.message_done = item.last_byte;
      end else if (item.last_byte) begin
        // A field still open at the last byte counts as truncation.
        if (error_seen_next == ST_OK &&
            (phase_next != PH_TAG || group_count_next != 4'd0)) begin
          final_status = ST_TRUNCATED;
        end else begin
          final_status = error_seen_next;
        end
        if (final_status != ST_OK) begin
          produce              = 1'b1;
          res_new              = '0;
          res_new.status       = final_status;
          res_new.message_done = 1'b1;
        end
      end

      // Every message starts from a clean slate.
      if (item.last_byte) begin
        phase_next         = PH_TAG;
        accumulator_next   = '0;
        group_count_next   = '0;
        held_field_next    = '0;
        held_type_next     = '0;
        start_offset_next  = '0;
        bytes_to_skip_next = '0;
        byte_offset_next   = '0;
        error_seen_next    = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      accumulator   <= '0;
      group_count   <= '0;
      held_field    <= '0;
      held_type     <= '0;
      start_offset  <= '0;
      bytes_to_skip <= '0;
      byte_offset   <= '0;
      error_seen    <= ST_OK;
    end else begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      group_count   <= group_count_next;
      held_field    <= held_field_next;
      held_type     <= held_type_next;
      start_offset  <= start_offset_next;
      bytes_to_skip <= bytes_to_skip_next;
      byte_offset   <= byte_offset_next;
      error_seen    <= error_seen_next;
    end
  end

  // Output register with a one-beat skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid;
      end else if (produce) begin
        result <= res_new;
      end
    end else if (produce) begin
      skid <= res_new;
    end
  end

endmodule

// ===== rtl/pfs_checker.sv =====
// Port-level checker for the protobuf field scanner and its bind to the
// top level. Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_checker
  import pfs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input scan_in_t  item,
  input logic      result_valid,
  input logic      result_stall,
  input scan_out_t result
);

  // A stalled result beat must hold.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Error beats carry only a status and close the message.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      result.message_done && result.field_id == 32'd0 &&
      result.wire_kind == 3'd0 && result.field_value == 64'd0 &&
      result.value_start == 16'd0 && result.value_end == 16'd0)
    else $error("error beat has nonzero field data");

  // Fixed-size and empty wire types report no value.
  a_no_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK &&
    result.wire_kind != WT_VARINT && result.wire_kind != WT_LEN |->
      result.field_value == 64'd0)
    else $error("value reported for a wire type without one");

  // A fixed32 field ends exactly its size after its start.
  a_fixed_span: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_OK && result.wire_kind == WT_FIXED32 |->
      result.value_end == result.value_start + 16'd4)
    else $error("fixed32 field span is not four bytes");

endmodule

bind protobuf_field_scanner_top pfs_checker u_pfs_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for protobuf_field_scanner_top: directed and random
// protobuf messages, each result checked against an in-bench scan model.
// Depends on pfs_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module testbench;
  import pfs_pkg::*;

  // Wire types without a value; the package only names the ones with a value.
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED_6  = 3'd6;
  localparam logic [2:0] WT_RESERVED_7  = 3'd7;

  localparam int OFFSET_MAX   = (1 << OFFSET_BITS_DEFAULT) - 1;
  localparam int RANDOM_BYTES = 1180;
  localparam int IDLE_PCT     = 37;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 1500000;

  logic      clk;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  scan_in_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  scan_out_t result;

  protobuf_field_scanner_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Scan model state, one copy of everything the block keeps per message.
  logic [1:0]  scan_phase;
  logic [63:0] varint_acc;
  logic [3:0]  varint_groups;
  logic [31:0] cur_field;
  logic [2:0]  cur_wire_kind;
  logic [31:0] cur_start;
  logic [63:0] skip_left;
  logic [31:0] msg_offset;
  logic [1:0]  msg_error;

  scan_out_t   expected_fields[$];
  logic [7:0]  msg_bytes[$];

  bit idle_on;
  bit stall_on;
  int cycle_count;
  int mismatches;
  int bytes_sent;
  int messages_sent;
  int fields_checked;
  int errors_checked;

  function automatic void clear_scan_state();
    scan_phase    = PH_TAG;
    varint_acc    = '0;
    varint_groups = '0;
    cur_field     = '0;
    cur_wire_kind = '0;
    cur_start     = '0;
    skip_left     = '0;
    msg_offset    = '0;
    msg_error     = ST_OK;
  endfunction

  // Advances the scan model by one accepted byte and queues any result.
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic        emit;
    logic [63:0] emit_val;
    logic [63:0] v;
    scan_out_t   res;
    emit     = 1'b0;
    emit_val = '0;
    v        = '0;
    res      = '0;
    if (msg_error == ST_OK) begin
      if (msg_offset >= OFFSET_MAX) begin
        msg_error = ST_MSG_LONG;
      end else begin
        msg_offset++;
        if (scan_phase == PH_TAG || scan_phase == PH_VARINT) begin
          varint_acc |= {57'd0, b[6:0]} << (7 * varint_groups);
          if (b[7]) begin
            if (varint_groups >= LAST_GROUP) msg_error = ST_VARINT_LONG;
            else varint_groups++;
          end else begin
            v             = varint_acc;
            varint_acc    = '0;
            varint_groups = '0;
            if (scan_phase == PH_TAG) begin
              cur_field     = v[34:3];
              cur_wire_kind = v[2:0];
              cur_start     = msg_offset;
              case (cur_wire_kind)
                WT_VARINT, WT_LEN: scan_phase = PH_VARINT;
                WT_FIXED64: begin
                  scan_phase = PH_SKIP;
                  skip_left  = 64'd8;
                end
                WT_FIXED32: begin
                  scan_phase = PH_SKIP;
                  skip_left  = 64'd4;
                end
                default: emit = 1'b1;
              endcase
            end else if (cur_wire_kind == WT_LEN && v != 0) begin
              scan_phase = PH_SKIP;
              skip_left  = v;
              varint_acc = v;
            end else begin
              emit     = 1'b1;
              emit_val = v;
            end
          end
        end else begin
          if (skip_left != 0) skip_left--;
          if (skip_left == 0) begin
            emit       = 1'b1;
            emit_val   = (cur_wire_kind == WT_LEN) ? varint_acc : 64'd0;
            varint_acc = '0;
          end
        end
      end
    end

    if (emit) begin
      scan_phase       = PH_TAG;
      res.field_id     = cur_field;
      res.wire_kind    = cur_wire_kind;
      res.field_value  = emit_val;
      res.value_start  = cur_start[15:0];
      res.value_end    = msg_offset[15:0];
      res.status       = ST_OK;
      res.message_done = last;
      expected_fields.push_back(res);
      if (last) clear_scan_state();
    end else if (last) begin
      // A field left open by the last byte counts as truncated.
      if (msg_error == ST_OK && (scan_phase != PH_TAG || varint_groups != 0))
        msg_error = ST_TRUNCATED;
      if (msg_error != ST_OK) begin
        res.status       = msg_error;
        res.message_done = 1'b1;
        expected_fields.push_back(res);
      end
      clear_scan_state();
    end
  endfunction

  task automatic report_mismatch(input string what, input scan_out_t want,
                                 input scan_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected fn=%0d wt=%0d val=%h start=%0d end=%0d st=%0d done=%0b",
               $realtime, what, want.field_id, want.wire_kind, want.field_value,
               want.value_start, want.value_end, want.status, want.message_done);
      $display("            got      fn=%0d wt=%0d val=%h start=%0d end=%0d st=%0d done=%0b",
               got.field_id, got.wire_kind, got.field_value,
               got.value_start, got.value_end, got.status, got.message_done);
    end
  endtask

  // Result side: random stall, and every accepted beat checked in order.
  always @(posedge clk) begin
    result_stall <= stall_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : result_check
    scan_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("result with none expected", '0, result);
      end else begin
        want = expected_fields.pop_front();
        if (result.field_id     !== want.field_id     ||
            result.wire_kind    !== want.wire_kind    ||
            result.field_value  !== want.field_value  ||
            result.value_start  !== want.value_start  ||
            result.value_end    !== want.value_end    ||
            result.status       !== want.status       ||
            result.message_done !== want.message_done)
          report_mismatch("field mismatch", want, result);
        if (want.status == ST_OK) fields_checked++;
        else errors_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_fields.size());
      $display("status: fail");
      $finish;
    end
  end

  // Sends one byte beat; idle cycles before it carry junk with valid low.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      item       <= {8'($urandom), 1'($urandom)};
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {b, last};
    do @(posedge clk); while (item_stall);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sends the built message, last_byte on its final byte. A pause_at index
  // holds the sender there until every outstanding result has come back.
  task automatic send_message(input int pause_at);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if (i == pause_at) wait_for_results();
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    msg_bytes.delete();
    messages_sent++;
  endtask

  // Least significant group first; pad adds redundant zero groups, up to ten.
  task automatic put_varint(input logic [63:0] value, input int pad);
    int          groups_min;
    int          total;
    logic [63:0] part;
    groups_min = 1;
    while (groups_min < 10 && (value >> (7 * groups_min)) != 0) groups_min++;
    total = (groups_min + pad > 10) ? 10 : groups_min + pad;
    for (int i = 0; i < total; i++) begin
      part = value >> (7 * i);
      msg_bytes.push_back({(i < total - 1), part[6:0]});
    end
  endtask

  // For a length-delimited field, value is the length and the body is random.
  task automatic add_field(input logic [31:0] field, input logic [2:0] wt,
                           input logic [63:0] value, input int tag_pad,
                           input int value_pad);
    put_varint({29'd0, field, wt}, tag_pad);
    case (wt)
      WT_VARINT: put_varint(value, value_pad);
      WT_LEN: begin
        put_varint(value, value_pad);
        repeat (value) msg_bytes.push_back(8'($urandom));
      end
      WT_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
      WT_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic add_random_field();
    logic [31:0] field;
    logic [2:0]  wt;
    logic [63:0] value;
    int          r;
    r = $urandom_range(9);
    if (r < 6)      field = $urandom_range(15, 1);
    else if (r < 8) field = $urandom;
    else if (r < 9) field = '0;
    else            field = '1;
    r = $urandom_range(11);
    if (r < 3)       wt = WT_VARINT;
    else if (r < 6)  wt = WT_LEN;
    else if (r < 8)  wt = WT_FIXED64;
    else if (r < 10) wt = WT_FIXED32;
    else             wt = 3'($urandom_range(7));
    if (wt == WT_LEN)
      value = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
    else if ($urandom_range(15) == 0)
      value = '1;
    else
      value = {$urandom, $urandom} >> $urandom_range(63);
    add_field(field, wt, value,
              ($urandom_range(9) == 0) ? $urandom_range(3) : 0,
              ($urandom_range(9) == 0) ? $urandom_range(3) : 0);
  endtask

  // Mostly well-formed messages; the rest are cut short, carry an over-long
  // varint, or are plain noise.
  task automatic build_random_message();
    int kind;
    int cut;
    repeat ($urandom_range(4, 1)) add_random_field();
    kind = $urandom_range(99);
    if (kind < 8) begin
      if (msg_bytes.size() > 1) begin
        cut = $urandom_range(msg_bytes.size() - 1, 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end else if (kind < 13) begin
      if ($urandom_range(1)) put_varint({29'd0, 32'($urandom_range(15)), WT_VARINT}, 0);
      repeat (10) msg_bytes.push_back({1'b1, 7'($urandom)});
      repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
      if ($urandom_range(1)) add_random_field();
    end else if (kind < 18) begin
      msg_bytes.delete();
      repeat ($urandom_range(8, 1)) msg_bytes.push_back(8'($urandom));
    end
  endtask

  // One field of every wire type in a single message, with the sender held
  // mid-message until all earlier results are back. Then messages of empty fields only.
  task automatic test_wire_types();
    add_field(32'd1, WT_VARINT, 64'd300, 0, 0);
    add_field(32'd2, WT_FIXED64, '0, 0, 0);
    add_field(32'd3, WT_LEN, 64'd3, 0, 0);
    add_field(32'd4, WT_GROUP_START, '0, 0, 0);
    add_field(32'd5, WT_GROUP_END, '0, 0, 0);
    add_field(32'd6, WT_FIXED32, '0, 0, 0);
    add_field(32'd7, WT_RESERVED_6, '0, 0, 0);
    add_field(32'd8, WT_RESERVED_7, '0, 0, 0);
    add_field(32'd9, WT_VARINT, 64'd1, 0, 0);
    send_message(12);
    add_field(32'd3, WT_GROUP_START, '0, 0, 0);
    send_message(-1);
    add_field(32'd15, WT_GROUP_END, '0, 0, 0);
    add_field(32'd16, WT_RESERVED_7, '0, 0, 0);
    send_message(-1);
    wait_for_results();
  endtask

  task automatic test_value_extremes();
    add_field('0, WT_VARINT, '0, 0, 0);
    add_field('1, WT_VARINT, '1, 0, 0);
    // Ten-byte varint whose final group spills past bit 63.
    add_field(32'd5, WT_VARINT, '0, 0, 0);
    void'(msg_bytes.pop_back());
    repeat (9) msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h7F);
    add_field(32'd2, WT_LEN, '0, 0, 0);
    add_field(32'd3, WT_VARINT, 64'd1, 9, 0);
    add_field(32'd4, WT_LEN, 64'd2, 2, 7);
    // Tag with bits above bit 34 set: those bits are dropped.
    put_varint(64'hFFFF_FFFF_FFFF_FFFD, 0);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    add_field(32'd6, WT_LEN, 64'd2, 0, 0);
    msg_bytes[msg_bytes.size() - 2] = 8'h00;
    msg_bytes[msg_bytes.size() - 1] = 8'hFF;
    send_message(-1);
    // Zero length on the final byte closes the message.
    add_field(32'd7, WT_LEN, '0, 0, 0);
    send_message(-1);
    wait_for_results();
  endtask

  task automatic test_truncation();
    msg_bytes.push_back(8'h80);
    send_message(-1);
    put_varint({29'd0, 32'd1, WT_VARINT}, 0);
    send_message(-1);
    put_varint({29'd0, 32'd2, WT_FIXED64}, 0);
    repeat (3) msg_bytes.push_back(8'($urandom));
    send_message(-1);
    put_varint({29'd0, 32'd3, WT_LEN}, 0);
    msg_bytes.push_back(8'd5);
    repeat (2) msg_bytes.push_back(8'($urandom));
    send_message(-1);
    put_varint({29'd0, 32'd4, WT_LEN}, 0);
    msg_bytes.push_back(8'h85);
    send_message(-1);
    add_field(32'd5, WT_FIXED32, '0, 0, 0);
    msg_bytes.push_back(8'h88);
    send_message(-1);
    add_field(32'd6, WT_VARINT, 64'd99, 0, 0);
    put_varint({29'd0, 32'd7, WT_FIXED32}, 0);
    send_message(-1);
    wait_for_results();
  endtask

  task automatic test_varint_overrun();
    // Over-long tag, then bytes that would form fields but are ignored.
    repeat (10) msg_bytes.push_back(8'hFF);
    add_field(32'd1, WT_VARINT, 64'd1, 0, 0);
    send_message(-1);
    // Over-long value after a good field.
    add_field(32'd2, WT_FIXED32, '0, 0, 0);
    put_varint({29'd0, 32'd3, WT_VARINT}, 0);
    repeat (11) msg_bytes.push_back(8'h80);
    msg_bytes.push_back(8'h00);
    send_message(-1);
    // Overrun on the final byte itself.
    put_varint({29'd0, 32'd4, WT_LEN}, 0);
    repeat (10) msg_bytes.push_back(8'h81);
    send_message(-1);
    wait_for_results();
  endtask

  // Random messages: a first stretch with both sides streaming flat out,
  // then random gaps and stalls for the rest.
  task automatic test_random_messages();
    int first;
    first    = bytes_sent;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    while (bytes_sent - first < RANDOM_BYTES) begin
      if (bytes_sent - first > RANDOM_BYTES / 4) begin
        idle_on  = 1'b1;
        stall_on = 1'b1;
      end
      build_random_message();
      send_message(-1);
    end
    wait_for_results();
  endtask

  initial begin
    clear_scan_state();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_wire_types();
    test_value_extremes();
    test_truncation();
    test_varint_overrun();
    test_random_messages();

    if (expected_fields.size() != 0)
      report_mismatch("expected result never arrived", expected_fields[0], '0);
    $display("covered %0d byte beats in %0d messages: all wire types, extreme values,",
             bytes_sent, messages_sent);
    $display("truncation, varint overrun, random streams; %0d fields, %0d error results, %0d bad",
             fields_checked, errors_checked, mismatches);
    if (mismatches == 0 && expected_fields.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
